### hdl/oaid_pkg.sv
// Shared types and codes for the ordered array insert/delete block.
// No dependencies; imported by the top level.
package oaid_pkg;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 3'd0,
    K_APPEND = 3'd1,
    K_DELETE = 3'd2,
    K_DROP   = 3'd3,
    K_READ   = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOVE,
    S_PUT,
    S_DONE
  } state_t;

endpackage

### hdl/ordered_array_insert_delete_top.sv
// Ordered array with insert, append, delete, drop-last and read requests.
// Requests that touch no entry go straight to the done state; a read takes one
// RAM read, and each moved entry takes one RAM read and one RAM write; insert
// in the middle adds a final write of the new value. One request in flight at a
// time, paced by the registered read of the entry RAM.
// Reset clears the fill count and the handshake state; entries are not cleared.
module ordered_array_insert_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // value[31:0], position[35:32], zero fill
  input  logic [39:0]                             s_tdata,
  // kind[2:0]
  input  logic [oaid_pkg::KIND_W-1:0]             s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // status[1:0], count[CW+1:2], read_value above, zero fill
  output logic [((oaid_pkg::STAT_W + $clog2(CAPACITY+1) + oaid_pkg::VALUE_W + 7) / 8) * 8 - 1:0]
                                                  m_tdata
);

  import oaid_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int ODW  = ((STAT_W + CW + VALUE_W + 7) / 8) * 8;
  localparam int OPAD = ODW - STAT_W - CW - VALUE_W;

  state_t            state, state_next;
  kind_t             kind_q, kind_next;
  logic [AW-1:0]     idx, idx_next;
  logic [AW-1:0]     pos_q, pos_next;
  logic [VALUE_W-1:0] val_q, val_next;
  status_t           st_q, st_next;
  logic [CW-1:0]     cnt_q, cnt_next;
  logic [VALUE_W-1:0] rd_q, rd_next;
  logic [CW-1:0]     count, count_next;

  logic [STAT_W-1:0]  out_status;
  logic [CW-1:0]      out_count;
  logic [VALUE_W-1:0] out_rd;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] wdata, rdata;

  logic               in_fire;
  logic [VALUE_W-1:0] in_value;
  logic [CMPW-1:0]    posx, cntx;
  logic               out_free;

  assign in_value = s_tdata[VALUE_W-1:0];
  assign posx     = CMPW'(s_tdata[VALUE_W+POS_W-1:VALUE_W]);
  assign cntx     = CMPW'(count);
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  oaid_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    kind_next  = kind_q;
    idx_next   = idx;
    pos_next   = pos_q;
    val_next   = val_q;
    st_next    = st_q;
    cnt_next   = cnt_q;
    rd_next    = rd_q;
    count_next = count;
    we         = 1'b0;
    waddr      = idx;
    wdata      = val_q;
    raddr      = idx;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          kind_next  = kind_t'(s_tuser);
          pos_next   = AW'(posx);
          val_next   = in_value;
          idx_next   = AW'(posx);
          st_next    = ST_OK;
          cnt_next   = count;
          rd_next    = '0;
          state_next = S_DONE;
          case (kind_t'(s_tuser))
            K_INSERT: begin
              if (cntx == CMPW'(CAPACITY)) begin
                st_next = ST_FULL;
              end else if (posx > cntx || posx >= CMPW'(CAPACITY)) begin
                st_next = ST_BADPOS;
              end else begin
                cnt_next = count + 1'b1;
                if (posx == cntx) begin
                  we    = 1'b1;
                  waddr = AW'(posx);
                  wdata = in_value;
                end else begin
                  idx_next   = AW'(count);
                  state_next = S_READ;
                end
              end
            end
            K_APPEND: begin
              if (cntx == CMPW'(CAPACITY)) begin
                st_next = ST_FULL;
              end else begin
                cnt_next = count + 1'b1;
                we       = 1'b1;
                waddr    = AW'(count);
                wdata    = in_value;
              end
            end
            K_DELETE: begin
              if (count == '0) begin
                st_next = ST_EMPTY;
              end else if (posx >= cntx) begin
                st_next = ST_BADPOS;
              end else begin
                cnt_next = count - 1'b1;
                if (posx + 1'b1 != cntx) begin
                  state_next = S_READ;
                end
              end
            end
            K_DROP: begin
              if (count == '0) begin
                st_next = ST_EMPTY;
              end else begin
                cnt_next = count - 1'b1;
              end
            end
            K_READ: begin
              if (count == '0) begin
                st_next = ST_EMPTY;
              end else if (posx >= cntx) begin
                st_next = ST_BADPOS;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              st_next = ST_BADPOS;
            end
          endcase
        end
      end
      S_READ: begin
        case (kind_q)
          K_INSERT: raddr = AW'(idx - 1'b1);
          K_DELETE: raddr = AW'(idx + 1'b1);
          default:  raddr = idx;
        endcase
        state_next = S_MOVE;
      end
      S_MOVE: begin
        case (kind_q)
          K_INSERT: begin
            we    = 1'b1;
            waddr = idx;
            wdata = rdata;
            if (AW'(idx - 1'b1) == pos_q) begin
              state_next = S_PUT;
            end else begin
              idx_next   = AW'(idx - 1'b1);
              state_next = S_READ;
            end
          end
          K_DELETE: begin
            we    = 1'b1;
            waddr = idx;
            wdata = rdata;
            if (CW'(idx) + CW'(2) == count) begin
              state_next = S_DONE;
            end else begin
              idx_next   = AW'(idx + 1'b1);
              state_next = S_READ;
            end
          end
          default: begin
            rd_next    = rdata;
            state_next = S_DONE;
          end
        endcase
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = pos_q;
        wdata      = val_q;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          count_next = cnt_q;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_q <= kind_next;
    idx    <= idx_next;
    pos_q  <= pos_next;
    val_q  <= val_next;
    st_q   <= st_next;
    cnt_q  <= cnt_next;
    rd_q   <= rd_next;
    if (state == S_DONE && out_free) begin
      out_status <= st_q;
      out_count  <= cnt_q;
      out_rd     <= rd_q;
    end
  end

  assign m_tdata = {OPAD'(0), out_rd, out_count, out_status};

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("accepted a word while a request is in flight");

  a_insert_above_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && kind_q == K_INSERT) |-> (idx > pos_q))
    else $error("insert shift moved below the target position");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result word raised outside the done state");
`endif

endmodule

### hdl/oaid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oaid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
